FILE: rtl/core/deadline_task_timer_assert.svh
// ----------------------------------------------------------------------------
// deadline_task_timer_assert.svh
// Assertion macros used by the deadline task timer checker.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TASK_TIMER_ASSERT_SVH
`define DEADLINE_TASK_TIMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deadline_task_timer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deadline_task_timer: next-cycle check failed");

`endif

FILE: rtl/core/dtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg
// Types, codes and constants shared by the deadline task timer modules.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned MAX_TASKS_DEF = 32;
  localparam int unsigned ID_MAX_SLOTS  = 32;
  localparam int unsigned TimeW         = 48;
  localparam int unsigned IdW           = 5;
  localparam int unsigned DurW          = 20;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_DUP      = 3'd1,
    KIND_DELETED  = 3'd2,
    KIND_NOTFOUND = 3'd3,
    KIND_EXPIRED  = 3'd4,
    KIND_NOTHING  = 3'd5
  } kind_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [IdW-1:0]  task_id;
    logic [DurW-1:0] duration;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [IdW-1:0] task_id_res;
    logic           last;
  } out_beat_t;

  typedef struct packed {
    alu_op_e          op;
    logic [TimeW-1:0] a;
    logic [TimeW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TimeW-1:0] sum;
    logic             lt;
    logic             eq;
  } alu_rsp_t;

endpackage

FILE: rtl/core/dtt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dtt_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_alu
// Shared 48-bit adder: saturating add, or subtract used as a compare.
// ----------------------------------------------------------------------------
module dtt_alu (
  input  dtt_pkg::alu_req_t req,
  output dtt_pkg::alu_rsp_t rsp
);

  logic [dtt_pkg::TimeW-1:0] b_op;
  logic                      cin;
  logic [dtt_pkg::TimeW:0]   raw;

  always_comb begin
    b_op = (req.op == dtt_pkg::ALU_SUB) ? ~req.b : req.b;
    cin  = (req.op == dtt_pkg::ALU_SUB);
    raw  = {1'b0, req.a} + {1'b0, b_op} + {{dtt_pkg::TimeW{1'b0}}, cin};
    // On an add a carry out means overflow, so the sum pins at all ones.
    // On a subtract a missing carry out means a borrow, that is a < b.
    rsp.sum = raw[dtt_pkg::TimeW] ? {dtt_pkg::TimeW{1'b1}} : raw[dtt_pkg::TimeW-1:0];
    rsp.lt  = ~raw[dtt_pkg::TimeW];
    rsp.eq  = (raw[dtt_pkg::TimeW-1:0] == '0);
  end

endmodule

FILE: rtl/core/deadline_task_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_task_timer
// Table of timed tasks with absolute deadlines, expired on one-second ticks.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall high until its last
// result beat is in the output register. An add or a delete passes through
// S_EXEC. A tick passes through S_TICK, then S_SCAN and S_PICK once for
// each task that expires and once more to end. The table has MAX_TASKS task
// slots, at most 32, and every expired task costs one full pass over the
// deadline RAM, which has a single read port, and every deadline goes
// through the one shared 48-bit adder that also does the compare. Results
// come out in deadline order, ties going to the lower id; an empty tick
// gives one "nothing" beat. Deadlines and the current time saturate at
// 2^48-1. Stalls on the output side hold the block in S_EXEC or S_PICK.
module deadline_task_timer #(
  parameter int unsigned MAX_TASKS = dtt_pkg::MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtt_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtt_pkg::out_beat_t out_data
);

  localparam int unsigned NumSlots = (MAX_TASKS < dtt_pkg::ID_MAX_SLOTS) ?
                                     MAX_TASKS : dtt_pkg::ID_MAX_SLOTS;
  localparam int unsigned IdxW     = $clog2(NumSlots);
  localparam int unsigned CntW     = IdxW + 1;
  localparam logic [CntW-1:0] SlotCnt = CntW'(NumSlots);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_SCAN,
    S_PICK
  } state_t;

  state_t                    state;
  dtt_pkg::in_beat_t         item;
  logic [NumSlots-1:0]       active;
  logic [dtt_pkg::TimeW-1:0] now;
  logic [CntW-1:0]           idx;
  logic                      pend;
  logic [IdxW-1:0]           pend_idx;
  logic                      found;
  logic [IdxW-1:0]           best_id;
  logic [dtt_pkg::TimeW-1:0] best_dl;
  logic                      held;
  logic [IdxW-1:0]           held_id;

  dtt_pkg::alu_req_t         alu_req;
  dtt_pkg::alu_rsp_t         alu_rsp;
  logic                      ram_we;
  logic [IdxW-1:0]           ram_raddr;
  logic [dtt_pkg::TimeW-1:0] ram_rdata;

  logic                      out_free;
  logic                      in_table;
  logic [IdxW-1:0]           slot;
  logic                      slot_active;
  logic                      add_ok;
  logic                      del_ok;
  logic                      take;
  logic                      pick_out;

  dtt_ram #(
    .WIDTH(dtt_pkg::TimeW),
    .DEPTH(NumSlots)
  ) u_deadline_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(alu_rsp.sum),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dtt_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_comb begin
    out_free    = !out_valid || !out_stall;
    in_stall    = (state != S_IDLE);
    in_table    = ({1'b0, item.task_id} < 6'(NumSlots));
    slot        = item.task_id[IdxW-1:0];
    slot_active = in_table && active[slot];
    add_ok      = (item.opcode == dtt_pkg::OP_ADD) && in_table && !slot_active;
    del_ok      = (item.opcode == dtt_pkg::OP_DEL) && slot_active;
    ram_we      = (state == S_EXEC) && out_free && add_ok;
    ram_raddr   = (idx < SlotCnt) ? idx[IdxW-1:0] : '0;

    case (state)
      S_EXEC: begin
        alu_req.op = dtt_pkg::ALU_ADD;
        alu_req.a  = now;
        alu_req.b  = dtt_pkg::TimeW'(item.duration);
      end
      S_TICK: begin
        alu_req.op = dtt_pkg::ALU_ADD;
        alu_req.a  = now;
        alu_req.b  = dtt_pkg::TimeW'(1);
      end
      default: begin
        // Until a candidate is found, the bound is the current time itself
        // and equality counts; afterwards only a strictly earlier deadline
        // wins, which keeps the lower id on a tie.
        alu_req.op = dtt_pkg::ALU_SUB;
        alu_req.a  = ram_rdata;
        alu_req.b  = found ? best_dl : now;
      end
    endcase

    take     = pend && active[pend_idx] && (alu_rsp.lt || (!found && alu_rsp.eq));
    pick_out = !(found && !held);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      active    <= '0;
      now       <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      held      <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            case (in_data.opcode)
              dtt_pkg::OP_ADD, dtt_pkg::OP_DEL: state <= S_EXEC;
              dtt_pkg::OP_TICK:                 state <= S_TICK;
              default:                          state <= S_IDLE;
            endcase
          end
        end

        S_EXEC: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.task_id_res <= item.task_id;
            out_data.last        <= 1'b1;
            if (item.opcode == dtt_pkg::OP_ADD) begin
              out_data.kind <= add_ok ? dtt_pkg::KIND_ADDED : dtt_pkg::KIND_DUP;
            end else begin
              out_data.kind <= del_ok ? dtt_pkg::KIND_DELETED : dtt_pkg::KIND_NOTFOUND;
            end
            if (add_ok) begin
              active[slot] <= 1'b1;
            end
            if (del_ok) begin
              active[slot] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        S_TICK: begin
          now   <= alu_rsp.sum;
          idx   <= '0;
          pend  <= 1'b0;
          found <= 1'b0;
          held  <= 1'b0;
          state <= S_SCAN;
        end

        S_SCAN: begin
          if (take) begin
            found   <= 1'b1;
            best_id <= pend_idx;
            best_dl <= ram_rdata;
          end
          if (idx < SlotCnt) begin
            pend     <= 1'b1;
            pend_idx <= idx[IdxW-1:0];
            idx      <= idx + CntW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_PICK;
            end
          end
        end

        S_PICK: begin
          // A found task is held back one pass, so that its last flag is
          // known when it is sent.
          if (!pick_out || out_free) begin
            if (pick_out) begin
              out_valid <= 1'b1;
              if (held) begin
                out_data.kind        <= dtt_pkg::KIND_EXPIRED;
                out_data.task_id_res <= dtt_pkg::IdW'(held_id);
                out_data.last        <= !found;
              end else begin
                out_data.kind        <= dtt_pkg::KIND_NOTHING;
                out_data.task_id_res <= '0;
                out_data.last        <= 1'b1;
              end
            end
            if (found) begin
              active[best_id] <= 1'b0;
              held            <= 1'b1;
              held_id         <= best_id;
              idx             <= '0;
              pend            <= 1'b0;
              found           <= 1'b0;
              state           <= S_SCAN;
            end else begin
              held  <= 1'b0;
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/dtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks on the deadline task timer, bound to its top level.
// ----------------------------------------------------------------------------
`include "deadline_task_timer_assert.svh"

module dtt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input dtt_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dtt_pkg::out_beat_t out_data
);

  logic took_item;
  logic single_beat;
  logic nothing_beat;

  always_comb begin
    took_item    = in_valid && !in_stall && (in_data.opcode != dtt_pkg::OP_NOP);
    single_beat  = out_valid && (out_data.kind != dtt_pkg::KIND_EXPIRED);
    nothing_beat = out_valid && (out_data.kind == dtt_pkg::KIND_NOTHING);
  end

  // A stalled result beat stays in place unchanged.
  `DTT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // Any accepted item other than the unused opcode keeps the block busy.
  `DTT_ASSERT_NEXT(a_busy_after_accept, clk, rst, took_item, in_stall)

  // Only an expiry run can hold a beat that is not the last one.
  `DTT_ASSERT_NOW(a_last_single, clk, rst, single_beat, out_data.last)

  // An empty tick reports id zero.
  `DTT_ASSERT_NOW(a_nothing_id, clk, rst, nothing_beat, out_data.task_id_res == '0)

endmodule

bind deadline_task_timer dtt_checker u_dtt_checker (.*);
